// File: src/rolling_hash_pattern_matcher_assert.svh
// Assertion macros for the rolling hash matcher RTL (included by the back end, rhpm_roll).
`ifndef ROLLING_HASH_PATTERN_MATCHER_ASSERT_SVH
`define ROLLING_HASH_PATTERN_MATCHER_ASSERT_SVH
`ifndef SYNTH
`define RHPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RHPM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (expr)) else $error(msg);
`else
`define RHPM_ASSERT(lbl, prop, msg)
`define RHPM_ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

// File: src/rhpm_pkg.sv
// Shared types, constants and modular arithmetic for the rolling hash matcher.
package rhpm_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int HASH_W = 31;

  typedef logic [HASH_W-1:0] hash_t;

  localparam hash_t HASH_MOD = 31'h7FFF_FFFF;
  localparam hash_t HASH_ONE = 31'd1;

  // Per-item work codes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_SLIDE = 2'd2;

  typedef struct packed {
    logic        clr;     // clear window hash before this beat's update
    logic [1:0]  mode;
    logic        emit;    // beat produces a result
    logic [7:0]  sym;
    hash_t       tp;      // weight of the oldest byte
    hash_t       ph;      // pattern hash seen by this beat
    logic [31:0] wstart;
  } cmd_t;

  // x * 256 mod (2^31 - 1) is a rotate by 8
  function automatic hash_t rot8(input hash_t x);
    rot8 = {x[22:0], x[30:23]};
  endfunction

  // (256 * h + b) mod Q
  function automatic hash_t hash_push(input hash_t h, input logic [7:0] b);
    logic [31:0] t;
    t = {1'b0, rot8(h)} + {24'd0, b};
    if (t >= {1'b0, HASH_MOD}) begin
      t = t - {1'b0, HASH_MOD};
    end
    hash_push = t[30:0];
  endfunction

  // (a - b) mod Q with a, b already reduced
  function automatic hash_t mod_sub(input hash_t a, input hash_t b);
    logic [31:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[31]) begin
      d = d + {1'b0, HASH_MOD};
    end
    mod_sub = d[30:0];
  endfunction

  // 39-bit product mod Q: fold the high bits onto the low ones
  function automatic hash_t mod_fold(input logic [38:0] p);
    logic [31:0] t;
    t = {1'b0, p[30:0]} + {24'd0, p[38:31]};
    if (t >= {1'b0, HASH_MOD}) begin
      t = t - {1'b0, HASH_MOD};
    end
    mod_fold = t[30:0];
  endfunction

endpackage

// File: src/rhpm_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
module rhpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/rhpm_front.sv
// Front end: pattern state, ring pointer and fill bookkeeping, ring access issue.
module rhpm_front #(
  parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN_DEF,
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_accept,
  input  logic           in_kind,
  input  logic [7:0]     in_symbol,
  input  logic           in_start_req,
  output rhpm_pkg::cmd_t cmd,
  output logic           ram_wr_en,
  output logic [AW-1:0]  ram_wr_addr,
  output logic           ram_rd_en,
  output logic [AW-1:0]  ram_rd_addr
);
  import rhpm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = LW + 1;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_PATTERN);
  localparam logic [IW-1:0] MAX_I = IW'(MAX_PATTERN);
  localparam logic [AW:0]   MAX_A = (AW + 1)'(MAX_PATTERN);

  hash_t          ph_r, ph_nxt, ph_e;
  hash_t          tp_r, tp_nxt, tp_e;
  logic [LW-1:0]  pl_r, pl_nxt, pl_e;
  logic [AW-1:0]  rp_r, rp_nxt, rp_e;
  logic [LW-1:0]  fill_r, fill_nxt, fill_e;
  logic [31:0]    wc_r, wc_nxt, wc_e;
  logic           new_pat;
  logic           text_clr;
  logic [AW:0]    rp_inc;
  logic [AW-1:0]  rp_adv;
  logic [IW-1:0]  idx_full;
  logic [IW-1:0]  idx_wrap;

  always_comb begin
    new_pat  = !in_kind && in_start_req;
    text_clr = !in_kind || in_start_req;

    ph_e   = new_pat ? '0 : ph_r;
    tp_e   = new_pat ? HASH_ONE : tp_r;
    pl_e   = new_pat ? '0 : pl_r;
    rp_e   = text_clr ? '0 : rp_r;
    fill_e = text_clr ? '0 : fill_r;
    wc_e   = text_clr ? '0 : wc_r;

    rp_inc = {1'b0, rp_e} + (AW + 1)'(1);
    rp_adv = (rp_inc >= MAX_A) ? '0 : rp_inc[AW-1:0];

    // oldest byte sits pattern_length places behind the write pointer
    idx_full = IW'(rp_e) + MAX_I - IW'(pl_e);
    idx_wrap = (idx_full >= MAX_I) ? (idx_full - MAX_I) : idx_full;

    ph_nxt   = ph_e;
    tp_nxt   = tp_e;
    pl_nxt   = pl_e;
    rp_nxt   = rp_e;
    fill_nxt = fill_e;
    wc_nxt   = wc_e;

    cmd.clr    = text_clr;
    cmd.mode   = MODE_NONE;
    cmd.emit   = 1'b0;
    cmd.sym    = in_symbol;
    cmd.tp     = tp_e;
    cmd.ph     = ph_e;
    cmd.wstart = wc_e;

    ram_wr_en   = 1'b0;
    ram_wr_addr = rp_e;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_wrap[AW-1:0];

    if (!in_kind) begin
      // drop pattern bytes past capacity
      if (pl_e < MAX_L) begin
        if (pl_e != '0) begin
          tp_nxt = rot8(tp_e);
        end
        ph_nxt = hash_push(ph_e, in_symbol);
        pl_nxt = pl_e + LW'(1);
      end
    end else if (pl_e != '0) begin
      ram_wr_en = in_accept;
      rp_nxt    = rp_adv;
      if (fill_e < pl_e) begin
        cmd.mode = MODE_FILL;
        fill_nxt = fill_e + LW'(1);
        cmd.emit = (fill_nxt == pl_e);
      end else begin
        cmd.mode   = MODE_SLIDE;
        cmd.emit   = 1'b1;
        ram_rd_en  = in_accept;
        wc_nxt     = wc_e + 32'd1;
        cmd.wstart = wc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      tp_r   <= HASH_ONE;
      pl_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
      wc_r   <= '0;
    end else if (in_accept) begin
      ph_r   <= ph_nxt;
      tp_r   <= tp_nxt;
      pl_r   <= pl_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
      wc_r   <= wc_nxt;
    end
  end

endmodule

// File: src/rhpm_roll.sv
// Back end: oldest-byte weight, rolling window hash update and result register.
`include "rolling_hash_pattern_matcher_assert.svh"
module rhpm_roll (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_v,
  input  rhpm_pkg::cmd_t cmd,
  input  logic [7:0]     rd_data,
  output logic           s1_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_match,
  output logic [31:0]    out_window_start
);
  import rhpm_pkg::*;

  logic        s1_v_r;
  cmd_t        s1_r;
  logic        s2_v_r;
  cmd_t        s2_r;
  hash_t       s2_sub_r;
  hash_t       wh_r, wh_nxt;
  logic        out_valid_r;
  logic        out_match_r;
  logic [31:0] out_wstart_r;

  logic [38:0] prod;
  hash_t       sub_nxt;
  hash_t       h_base;
  logic        out_ready;
  logic        s2_go;
  logic        s2_ready;

  // weight of the byte leaving the window
  assign prod    = 39'(rd_data) * 39'(s1_r.tp);
  assign sub_nxt = mod_fold(prod);

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_go     = s2_v_r && (!s2_r.emit || out_ready);
  assign s2_ready  = !s2_v_r || s2_go;
  assign s1_ready  = !s1_v_r || s2_ready;

  always_comb begin
    h_base = s2_r.clr ? '0 : wh_r;
    case (s2_r.mode)
      MODE_FILL:  wh_nxt = hash_push(h_base, s2_r.sym);
      MODE_SLIDE: wh_nxt = hash_push(mod_sub(h_base, s2_sub_r), s2_r.sym);
      default:    wh_nxt = h_base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      wh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= cmd_v;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s2_go) begin
        wh_r <= wh_nxt;
      end
      if (out_ready) begin
        out_valid_r <= s2_go && s2_r.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && cmd_v) begin
      s1_r <= cmd;
    end
    if (s2_ready && s1_v_r) begin
      s2_r     <= s1_r;
      s2_sub_r <= sub_nxt;
    end
    if (out_ready && s2_go && s2_r.emit) begin
      out_match_r  <= (wh_nxt == s2_r.ph);
      out_wstart_r <= s2_r.wstart;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match        = out_match_r;
  assign out_window_start = out_wstart_r;

  `RHPM_ASSERT_ALWAYS(a_wh_reduced, wh_r != HASH_MOD, "window hash left its residue range")
  `RHPM_ASSERT(a_emit_lands, (s2_v_r && s2_r.emit && out_ready) |=> out_valid_r, "result beat lost")
  `RHPM_ASSERT(a_none_silent, (s2_v_r && s2_r.mode == MODE_NONE) |-> !s2_r.emit, "idle beat emits")
  `RHPM_ASSERT(a_sub_reduced, (s2_v_r && s2_r.mode == MODE_SLIDE) |-> s2_sub_r != HASH_MOD, "oldest weight unreduced")
  `RHPM_ASSERT(a_cmd_taken, cmd_v |-> s1_ready, "beat offered while first stage is full")

endmodule

// File: src/rolling_hash_pattern_matcher.sv
// Rolling-hash (base 256, mod 2^31-1) pattern matcher over a byte stream.
// Pattern bytes (kind 0) build the pattern hash; text bytes (kind 1) roll a window hash of
// the last m text bytes held in a MAX_PATTERN-byte ring RAM. One byte is taken every cycle
// while in_stall is low (out_stall can raise it); each result passes the stage-1 and stage-2
// registers into the output register. The rate is set by the window-hash update, one modular
// subtract, rotate and add per cycle, fed by one ring write and one ring read per byte. The ring
// needs no clearing pass after reset: an entry is read only after it has been written.
module rolling_hash_pattern_matcher #(
  parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_symbol,
  input  logic        in_start_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match,
  output logic [31:0] out_window_start
);
  import rhpm_pkg::*;

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic          s1_ready;
  logic          in_accept;
  cmd_t          cmd;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;

  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  rhpm_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_kind     (in_kind),
    .in_symbol   (in_symbol),
    .in_start_req(in_start_req),
    .cmd         (cmd),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr)
  );

  rhpm_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PATTERN)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(in_symbol),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  rhpm_roll u_roll (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_v           (in_accept),
    .cmd             (cmd),
    .rd_data         (ram_rd_data),
    .s1_ready        (s1_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match       (out_match),
    .out_window_start(out_window_start)
  );

endmodule

// File: test/tb_rolling_hash_pattern_matcher.sv
// Testbench for the rolling-hash pattern matcher: directed and random byte streams.
`timescale 1ns / 100ps

module tb_rolling_hash_pattern_matcher;

  localparam int          RING_DEPTH  = rhpm_pkg::MAX_PATTERN_DEF;
  localparam logic [63:0] HASH_Q      = 64'd2147483647;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 12;

  localparam bit KIND_PATTERN = 1'b0;
  localparam bit KIND_TEXT    = 1'b1;

  typedef struct {
    bit          hit;
    logic [31:0] wstart;
  } window_result_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_kind      = 1'b0;
  logic [7:0]  in_symbol    = 8'd0;
  logic        in_start_req = 1'b0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_match;
  logic [31:0] out_window_start;

  // Matcher state as seen by the prediction side
  rhpm_pkg::hash_t pat_hash   = '0;
  rhpm_pkg::hash_t top_weight = 31'd1;
  int unsigned     pat_len    = 0;
  rhpm_pkg::hash_t win_hash   = '0;
  logic [7:0]      text_ring [RING_DEPTH];
  int unsigned     ring_ptr   = 0;
  int unsigned     fill_len   = 0;
  logic [31:0]     win_count  = '0;

  window_result_t pending_windows [$];
  window_result_t oldest_window;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             fail_count     = 0;
  int             cycle_count    = 0;

  rolling_hash_pattern_matcher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_symbol        (in_symbol),
    .in_start_req     (in_start_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match        (out_match),
    .out_window_start (out_window_start)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic rhpm_pkg::hash_t mod_q(input logic [63:0] x);
    logic [63:0] r;
    r = x % HASH_Q;
    return r[30:0];
  endfunction

  function automatic rhpm_pkg::hash_t shift_in_byte(input rhpm_pkg::hash_t h,
                                                    input logic [7:0] b);
    return mod_q({33'd0, h} * 64'd256 + {56'd0, b});
  endfunction

  function automatic void drop_text();
    win_hash  = '0;
    ring_ptr  = 0;
    fill_len  = 0;
    win_count = '0;
  endfunction

  function automatic void store_text_byte(input logic [7:0] b);
    text_ring[ring_ptr] = b;
    ring_ptr = (ring_ptr + 1 >= RING_DEPTH) ? 0 : ring_ptr + 1;
  endfunction

  // Advance the matcher state by one accepted beat; queue the window result it yields
  function automatic void update_hash_state(input bit kind, input logic [7:0] sym,
                                            input bit start);
    int unsigned     idx;
    rhpm_pkg::hash_t removed;
    rhpm_pkg::hash_t rest;
    if (kind == KIND_PATTERN) begin
      if (start) begin
        pat_hash   = '0;
        top_weight = 31'd1;
        pat_len    = 0;
      end
      drop_text();
      if (pat_len < RING_DEPTH) begin
        if (pat_len > 0) top_weight = mod_q({33'd0, top_weight} * 64'd256);
        pat_hash = shift_in_byte(pat_hash, sym);
        pat_len++;
      end
      return;
    end
    if (start) drop_text();
    if (pat_len == 0) return;
    if (fill_len < pat_len) begin
      win_hash = shift_in_byte(win_hash, sym);
      store_text_byte(sym);
      fill_len++;
      if (fill_len < pat_len) return;
    end else begin
      idx = (ring_ptr + RING_DEPTH - pat_len) % RING_DEPTH;
      removed = mod_q({56'd0, text_ring[idx]} * {33'd0, top_weight});
      rest = mod_q({33'd0, win_hash} + HASH_Q - {33'd0, removed});
      win_hash = shift_in_byte(rest, sym);
      store_text_byte(sym);
      win_count = win_count + 32'd1;
    end
    pending_windows.push_back('{hit: (win_hash == pat_hash), wstart: win_count});
  endfunction

  task automatic send_byte(input bit kind, input logic [7:0] sym, input bit start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_symbol    <= sym;
    in_start_req <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_hash_state(kind, sym, start);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Compare every result beat against the oldest pending window
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        $error("unexpected result beat: match %0d, window_start %0d",
               out_match, out_window_start);
        fail_count++;
      end else begin
        oldest_window = pending_windows.pop_front();
        if (out_match !== oldest_window.hit) begin
          $error("match: expected %0d, got %0d", oldest_window.hit, out_match);
          fail_count++;
        end
        if (out_window_start !== oldest_window.wstart) begin
          $error("window_start: expected %0d, got %0d", oldest_window.wstart,
                 out_window_start);
          fail_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic test_empty_pattern();
    send_byte(KIND_TEXT, 8'hFF, 1'b1);
    send_byte(KIND_TEXT, 8'h00, 1'b0);
    send_byte(KIND_TEXT, 8'hA5, 1'b0);
    wait_for_results();
  endtask

  task automatic test_single_byte_pattern();
    send_byte(KIND_PATTERN, 8'hFF, 1'b1);
    send_byte(KIND_TEXT, 8'hFF, 1'b1);
    send_byte(KIND_TEXT, 8'h00, 1'b0);
    send_byte(KIND_TEXT, 8'hFF, 1'b0);
    wait_for_results();
  endtask

  task automatic test_fill_and_slide();
    send_byte(KIND_PATTERN, 8'h00, 1'b1);
    send_byte(KIND_PATTERN, 8'hFF, 1'b0);
    send_byte(KIND_PATTERN, 8'h80, 1'b0);
    send_byte(KIND_TEXT, 8'h00, 1'b0);
    send_byte(KIND_TEXT, 8'hFF, 1'b0);
    send_byte(KIND_TEXT, 8'h80, 1'b0);
    send_byte(KIND_TEXT, 8'h00, 1'b0);
    send_byte(KIND_TEXT, 8'hFF, 1'b0);
    // restart the text mid-window
    send_byte(KIND_TEXT, 8'h00, 1'b1);
    send_byte(KIND_TEXT, 8'hFF, 1'b0);
    send_byte(KIND_TEXT, 8'h80, 1'b0);
    wait_for_results();
  endtask

  task automatic test_pattern_cuts_text();
    send_byte(KIND_TEXT, 8'h7F, 1'b0);
    // extend the pattern; the current text window must be dropped
    send_byte(KIND_PATTERN, 8'h01, 1'b0);
    send_byte(KIND_TEXT, 8'h00, 1'b0);
    send_byte(KIND_TEXT, 8'hFF, 1'b0);
    send_byte(KIND_TEXT, 8'h80, 1'b0);
    send_byte(KIND_TEXT, 8'h01, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_streams(input int n_items, input int send_pct,
                                     input int stall_pct);
    logic [7:0] pool [4];
    logic [7:0] cur_pat [$];
    logic [7:0] b;
    int         sent;
    int         plen;
    int         tlen;
    int         alpha;
    int         j;
    int         k;
    int         r;
    bit         extend;
    bit         nk;
    bit         ns;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      for (k = 0; k < 4; k++) pool[k] = 8'($urandom_range(255));
      alpha = $urandom_range(1, 4);
      // open each run with a pattern long enough to overflow the ring
      if (sent == 0) plen = $urandom_range(65, 70);
      else if ($urandom_range(11) == 0) plen = $urandom_range(20, 66);
      else plen = $urandom_range(1, 8);
      extend = (sent != 0) && ($urandom_range(6) == 0);
      if (!extend) cur_pat.delete();
      for (j = 0; j < plen; j++) begin
        b = pool[$urandom_range(alpha - 1)];
        send_byte(KIND_PATTERN, b, (j == 0) && !extend);
        if (cur_pat.size() < RING_DEPTH) cur_pat.push_back(b);
        sent++;
      end
      tlen = cur_pat.size() + $urandom_range(0, 24);
      j = 0;
      while (j < tlen) begin
        r = $urandom_range(99);
        if (r < 12) begin
          // plant a copy of the pattern to force a hit
          foreach (cur_pat[k]) send_byte(KIND_TEXT, cur_pat[k], 1'b0);
          sent += cur_pat.size();
          j += cur_pat.size();
        end else if (r < 15) begin
          nk = 1'($urandom_range(1));
          ns = 1'($urandom_range(1));
          b  = 8'($urandom_range(255));
          send_byte(nk, b, ns);
          if (nk == KIND_PATTERN) begin
            if (ns) cur_pat.delete();
            if (cur_pat.size() < RING_DEPTH) cur_pat.push_back(b);
          end
          sent++;
          j++;
        end else begin
          send_byte(KIND_TEXT, pool[$urandom_range(alpha - 1)],
                    (r < 17) || ((j == 0) && $urandom_range(1)));
          sent++;
          j++;
        end
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_pattern();
    test_single_byte_pattern();
    test_fill_and_slide();
    test_pattern_cuts_text();
    test_random_streams(425, 0, 0);
    test_random_streams(425, 51, 0);
    test_random_streams(425, 0, 51);
    test_random_streams(425, 23, 23);
    recv_stall_pct = 0;
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
